[rtl/ptrc_pkg.sv]
package ptrc_pkg;

  localparam int ENTRIES = 8;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  localparam logic [31:0] LIMIT_RESET = 32'd1024;
  localparam logic [7:0] ADV_MAX = 8'd255;
  localparam logic [31:0] ADV_SPAN = 32'd256;

  localparam logic [3:0] CMD_FIND_TI = 4'd0;
  localparam logic [3:0] CMD_FIND_ID = 4'd1;
  localparam logic [3:0] CMD_FIND_TYPE = 4'd2;
  localparam logic [3:0] CMD_VERIFY = 4'd3;
  localparam logic [3:0] CMD_PAIR = 4'd4;
  localparam logic [3:0] CMD_SAVE = 4'd5;
  localparam logic [3:0] CMD_SET_VER = 4'd6;
  localparam logic [3:0] CMD_ERASE = 4'd7;
  localparam logic [3:0] CMD_ERASE_ALL = 4'd8;
  localparam logic [3:0] CMD_FIND_FREE = 4'd9;
  localparam logic [3:0] CMD_CLEAR = 4'd10;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [7:0]  peer_type;
    logic [31:0] ident;
    logic [31:0] code;
    logic [15:0] model;
    logic [31:0] version;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [3:0]  cmd;
    logic [7:0]  peer_type;
    logic [31:0] peer_id;
    logic [31:0] code_value;
    logic [2:0]  slot;
    logic [15:0] model_value;
    logic [31:0] version_value;
    logic [1:0]  clear_mask;
  } item_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] hit_slot;
    logic [7:0] advance;
    logic       code_store_due;
    logic       table_store_due;
  } result_t;

  typedef struct packed {
    logic   wr_en;
    idx_t   wr_addr;
    entry_t wr_data;
    logic   rd_en;
    idx_t   rd_addr;
  } mem_req_t;

endpackage

[rtl/pairing_table_rolling_code_check_unit.sv]
// Pairing table with rolling-code replay check. One command word goes in and one result
// word comes out. The peer records live in a single-port-read memory of ENTRIES rows with a
// registered read; active and written marks are flip-flops, so reset takes effect at once with
// no clearing pass. Lookups, save and set version read the rows one per cycle through that read
// port and stop at the first match; save then writes the matched row and set version writes it
// when the version changes. Verify reads its row, checks the code and writes it back when
// accepted; pair writes the free row; erase, erase all, find free and clear flags go straight
// to the result. A new command word is accepted while a finished result still waits in the output register.
module pairing_table_rolling_code_check_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  cmd,
  input  logic [7:0]  peer_type,
  input  logic [31:0] peer_id,
  input  logic [31:0] code_value,
  input  logic [2:0]  slot,
  input  logic [15:0] model_value,
  input  logic [31:0] version_value,
  input  logic [1:0]  clear_mask,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ok,
  output logic [2:0]  hit_slot,
  output logic [7:0]  advance,
  output logic        code_store_due,
  output logic        table_store_due
);
  import ptrc_pkg::*;

  logic [31:0] limit;
  item_t       item;
  mem_req_t    mem_req;
  entry_t      rd_data;
  logic        res_valid;
  logic        res_ready;
  result_t     res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_valid) begin
      limit <= cfg_data;
    end
  end

  assign item = item_t'{cmd, peer_type, peer_id, code_value, slot, model_value,
                        version_value, clear_mask};

  ptrc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk(clk),
    .wr_en(mem_req.wr_en),
    .wr_addr(mem_req.wr_addr),
    .wr_data(mem_req.wr_data),
    .rd_en(mem_req.rd_en),
    .rd_addr(mem_req.rd_addr),
    .rd_data(rd_data)
  );

  ptrc_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .item(item),
    .limit(limit),
    .mem_req(mem_req),
    .rd_data(rd_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
      ok <= res.ok;
      hit_slot <= res.hit_slot;
      advance <= res.advance;
      code_store_due <= res.code_store_due;
      table_store_due <= res.table_store_due;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_miss_slot_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> hit_slot == 3'd0)
    else $error("Result word without a hit carries a nonzero slot.");

  a_advance_needs_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (advance != 8'd0) |-> ok)
    else $error("Result word carries an advance without acceptance.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !res_valid)
    else $error("Command word taken while a result is still being handed over.");

  a_result_follows_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Command word accepted without the sequencer going busy.");
`endif

endmodule

[rtl/ptrc_ram.sv]
module ptrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/ptrc_ctrl.sv]
module ptrc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ptrc_pkg::item_t    item,
  input  logic [31:0]        limit,
  output ptrc_pkg::mem_req_t mem_req,
  input  ptrc_pkg::entry_t   rd_data,
  output logic               res_valid,
  input  logic               res_ready,
  output ptrc_pkg::result_t  res
);
  import ptrc_pkg::*;

  typedef enum logic [2:0] {IDLE, SCAN, VREAD, VCHECK, WRITE, RESULT} state_t;

  state_t             state;
  item_t              cur;
  logic [ENTRIES-1:0] active;
  logic [ENTRIES-1:0] filled;
  logic               code_flag;
  logic               table_flag;
  cnt_t               issue_cnt;
  logic               eval_vld;
  idx_t               eval_idx;
  idx_t               wr_addr;
  entry_t             wr_data;
  logic               wr_pair;
  logic               ok_r;
  logic [2:0]         hit_r;
  logic [7:0]         adv_r;

  logic   free_found;
  idx_t   free_idx;
  logic   in_slot_ok;
  idx_t   in_idx;
  idx_t   cur_idx;
  logic   issuing;
  logic   use_type;
  logic   use_id;
  logic   hit_now;
  logic   last_eval;
  entry_t rec_eff;
  entry_t rec_code;
  entry_t rec_ver;
  logic [31:0] code_gap;
  logic   code_accept;

  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_found = 1'b1;
        free_idx = idx_t'(i);
      end
    end
  end

  assign in_slot_ok = 32'(item.slot) < ENTRIES;
  assign in_idx = idx_t'(item.slot);
  assign cur_idx = idx_t'(cur.slot);
  assign issuing = (state == SCAN) && (issue_cnt < CNT_W'(ENTRIES));

  assign use_type = cur.cmd inside {CMD_FIND_TI, CMD_FIND_TYPE, CMD_SAVE, CMD_SET_VER};
  assign use_id = cur.cmd inside {CMD_FIND_TI, CMD_FIND_ID, CMD_SAVE};
  assign hit_now = eval_vld && active[eval_idx]
                   && (!use_type || (rd_data.peer_type == cur.peer_type))
                   && (!use_id || (rd_data.ident == cur.peer_id));
  assign last_eval = eval_idx == idx_t'(ENTRIES - 1);

  assign rec_eff = filled[cur_idx] ? rd_data : '0;
  assign code_gap = cur.code_value - rec_eff.code;
  assign code_accept = code_gap < limit;

  always_comb begin
    rec_code = rec_eff;
    rec_code.code = cur.code_value;
    rec_ver = rd_data;
    rec_ver.version = cur.version_value;
  end

  assign mem_req.wr_en = state == WRITE;
  assign mem_req.wr_addr = wr_addr;
  assign mem_req.wr_data = wr_data;
  assign mem_req.rd_en = issuing || (state == VREAD);
  assign mem_req.rd_addr = (state == VREAD) ? cur_idx : issue_cnt[IDX_W-1:0];

  assign in_ready = state == IDLE;
  assign res_valid = state == RESULT;
  assign res.ok = ok_r;
  assign res.hit_slot = hit_r;
  assign res.advance = adv_r;
  assign res.code_store_due = code_flag;
  assign res.table_store_due = table_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      active <= '0;
      filled <= '0;
      code_flag <= 1'b0;
      table_flag <= 1'b0;
      issue_cnt <= '0;
      eval_vld <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid) begin
            cur <= item;
            ok_r <= 1'b0;
            hit_r <= '0;
            adv_r <= '0;
            wr_pair <= 1'b0;
            state <= RESULT;
            case (item.cmd)
              CMD_FIND_TI, CMD_FIND_ID, CMD_FIND_TYPE, CMD_SAVE, CMD_SET_VER: begin
                issue_cnt <= '0;
                eval_vld <= 1'b0;
                state <= SCAN;
              end
              CMD_VERIFY: begin
                if (in_slot_ok) begin
                  state <= VREAD;
                end
              end
              CMD_PAIR: begin
                if (free_found) begin
                  wr_addr <= free_idx;
                  wr_data <= entry_t'{item.peer_type, item.peer_id, item.code_value,
                                      16'd0, 32'd0};
                  wr_pair <= 1'b1;
                  ok_r <= 1'b1;
                  hit_r <= 3'(free_idx);
                  code_flag <= 1'b1;
                  table_flag <= 1'b1;
                  state <= WRITE;
                end
              end
              CMD_ERASE: begin
                if (in_slot_ok) begin
                  active[in_idx] <= 1'b0;
                  filled[in_idx] <= 1'b0;
                  ok_r <= 1'b1;
                  hit_r <= item.slot;
                end
              end
              CMD_ERASE_ALL: begin
                active <= '0;
                filled <= '0;
                ok_r <= 1'b1;
              end
              CMD_FIND_FREE: begin
                ok_r <= free_found;
                hit_r <= free_found ? 3'(free_idx) : 3'd0;
              end
              CMD_CLEAR: begin
                if (item.clear_mask[0]) begin
                  code_flag <= 1'b0;
                end
                if (item.clear_mask[1]) begin
                  table_flag <= 1'b0;
                end
                ok_r <= 1'b1;
              end
              default: begin
                ok_r <= 1'b0;
              end
            endcase
          end
        end
        SCAN: begin
          if (issuing) begin
            issue_cnt <= issue_cnt + 1'b1;
            eval_vld <= 1'b1;
            eval_idx <= issue_cnt[IDX_W-1:0];
          end else begin
            eval_vld <= 1'b0;
          end
          if (eval_vld && (hit_now || last_eval)) begin
            eval_vld <= 1'b0;
            state <= RESULT;
            if (hit_now) begin
              ok_r <= 1'b1;
              hit_r <= 3'(eval_idx);
              wr_addr <= eval_idx;
              case (cur.cmd)
                CMD_SAVE: begin
                  wr_data <= entry_t'{cur.peer_type, cur.peer_id, cur.code_value,
                                      cur.model_value, cur.version_value};
                  state <= WRITE;
                end
                CMD_SET_VER: begin
                  if (rd_data.version != cur.version_value) begin
                    wr_data <= rec_ver;
                    table_flag <= 1'b1;
                    state <= WRITE;
                  end
                end
                default: begin
                  state <= RESULT;
                end
              endcase
            end
          end
        end
        VREAD: begin
          state <= VCHECK;
        end
        VCHECK: begin
          state <= RESULT;
          if (code_accept) begin
            wr_addr <= cur_idx;
            wr_data <= rec_code;
            ok_r <= 1'b1;
            hit_r <= cur.slot;
            adv_r <= (code_gap < ADV_SPAN) ? code_gap[7:0] : ADV_MAX;
            if (code_gap >= (limit >> 1)) begin
              code_flag <= 1'b1;
            end
            state <= WRITE;
          end
        end
        WRITE: begin
          filled[wr_addr] <= 1'b1;
          if (wr_pair) begin
            active[wr_addr] <= 1'b1;
          end
          state <= RESULT;
        end
        RESULT: begin
          if (res_ready) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

[tb/pairing_table_rolling_code_check_unit_tb.sv]
`timescale 1ns / 100ps

module pairing_table_rolling_code_check_unit_tb;
  import ptrc_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int ITEMS_PER_SETTING = 119;
  localparam int SETTINGS_RUN = 8;
  localparam logic [3:0] CMD_SPARE_LO = 4'd11;
  localparam logic [3:0] CMD_SPARE_HI = 4'd15;

  typedef struct {
    item_t   word;
    bit      typed;
    result_t want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  cmd = '0;
  logic [7:0]  peer_type = '0;
  logic [31:0] peer_id = '0;
  logic [31:0] code_value = '0;
  logic [2:0]  slot = '0;
  logic [15:0] model_value = '0;
  logic [31:0] version_value = '0;
  logic [1:0]  clear_mask = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        ok;
  logic [2:0]  hit_slot;
  logic [7:0]  advance;
  logic        code_store_due;
  logic        table_store_due;

  entry_t      peer_rec [ENTRIES];
  bit          peer_live [ENTRIES];
  bit          code_dirty;
  bit          table_dirty;
  logic [31:0] limit_now;
  result_t     due_results [$];
  plan_row_t   plan [$];
  int          fails = 0;
  int          quiet_cycles = 0;
  int          burst_left = 0;
  bit          pair_heavy = 1'b0;
  int          stall_style = 0;
  int          stall_count = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pairing_table_rolling_code_check_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .peer_type(peer_type),
    .peer_id(peer_id),
    .code_value(code_value),
    .slot(slot),
    .model_value(model_value),
    .version_value(version_value),
    .clear_mask(clear_mask),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .ok(ok),
    .hit_slot(hit_slot),
    .advance(advance),
    .code_store_due(code_store_due),
    .table_store_due(table_store_due)
  );

  function automatic void wipe_row(int i);
    peer_live[i] = 1'b0;
    peer_rec[i] = '0;
  endfunction

  function automatic int match_row(bit by_type, bit by_id, logic [7:0] t, logic [31:0] id);
    for (int i = 0; i < ENTRIES; i++) begin
      if (peer_live[i] && (!by_type || peer_rec[i].peer_type == t) &&
          (!by_id || peer_rec[i].ident == id)) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic int free_row();
    for (int i = 0; i < ENTRIES; i++) begin
      if (!peer_live[i]) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic result_t apply_command(item_t c);
    result_t     r;
    int          k;
    logic [31:0] gap;
    r = '0;
    k = -1;
    case (c.cmd)
      CMD_FIND_TI: k = match_row(1'b1, 1'b1, c.peer_type, c.peer_id);
      CMD_FIND_ID: k = match_row(1'b0, 1'b1, c.peer_type, c.peer_id);
      CMD_FIND_TYPE: k = match_row(1'b1, 1'b0, c.peer_type, c.peer_id);
      CMD_VERIFY: begin
        gap = c.code_value - peer_rec[c.slot].code;
        if (gap < limit_now) begin
          peer_rec[c.slot].code = c.code_value;
          r.advance = (gap < ADV_SPAN) ? gap[7:0] : ADV_MAX;
          if (gap >= limit_now / 2) begin
            code_dirty = 1'b1;
          end
          k = int'(c.slot);
        end
      end
      CMD_PAIR: begin
        k = free_row();
        if (k >= 0) begin
          wipe_row(k);
          peer_live[k] = 1'b1;
          peer_rec[k].peer_type = c.peer_type;
          peer_rec[k].ident = c.peer_id;
          peer_rec[k].code = c.code_value;
          code_dirty = 1'b1;
          table_dirty = 1'b1;
        end
      end
      CMD_SAVE: begin
        k = match_row(1'b1, 1'b1, c.peer_type, c.peer_id);
        if (k >= 0) begin
          peer_rec[k].code = c.code_value;
          peer_rec[k].model = c.model_value;
          peer_rec[k].version = c.version_value;
        end
      end
      CMD_SET_VER: begin
        k = match_row(1'b1, 1'b0, c.peer_type, c.peer_id);
        if (k >= 0 && peer_rec[k].version != c.version_value) begin
          peer_rec[k].version = c.version_value;
          table_dirty = 1'b1;
        end
      end
      CMD_ERASE: begin
        wipe_row(int'(c.slot));
        k = int'(c.slot);
      end
      CMD_ERASE_ALL: begin
        for (int i = 0; i < ENTRIES; i++) begin
          wipe_row(i);
        end
        r.ok = 1'b1;
      end
      CMD_FIND_FREE: k = free_row();
      CMD_CLEAR: begin
        if (c.clear_mask[0]) begin
          code_dirty = 1'b0;
        end
        if (c.clear_mask[1]) begin
          table_dirty = 1'b0;
        end
        r.ok = 1'b1;
      end
      default: ;
    endcase
    if (k >= 0) begin
      r.ok = 1'b1;
      r.hit_slot = k[2:0];
    end
    r.code_store_due = code_dirty;
    r.table_store_due = table_dirty;
    return r;
  endfunction

  function automatic plan_row_t step(logic [3:0] op, logic [7:0] t, logic [31:0] id,
                                     logic [31:0] code, logic [2:0] s, logic [15:0] m,
                                     logic [31:0] v, logic [1:0] mask, bit typed = 1'b0,
                                     result_t want = '0);
    plan_row_t row;
    row.word = {op, t, id, code, s, m, v, mask};
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  // Most commands are steered toward live entries and toward codes near the stored one,
  // so that lookups hit and verify lands on both sides of the distance limit.
  function automatic item_t random_command();
    item_t       c;
    int          pick;
    int          j;
    int          k;
    logic [31:0] base;
    c = '0;
    c.peer_type = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    c.peer_id = $urandom;
    c.code_value = $urandom;
    c.slot = 3'($urandom);
    c.model_value = 16'($urandom);
    c.version_value = $urandom;
    c.clear_mask = 2'($urandom);
    j = $urandom_range(0, ENTRIES - 1);
    if (peer_live[j] && $urandom_range(0, 9) < 7) begin
      c.peer_type = peer_rec[j].peer_type;
      c.peer_id = peer_rec[j].ident;
    end
    pick = $urandom_range(0, 99);
    if (pick < 10) c.cmd = CMD_FIND_TI;
    else if (pick < 15) c.cmd = CMD_FIND_ID;
    else if (pick < 20) c.cmd = CMD_FIND_TYPE;
    else if (pick < 42) c.cmd = CMD_VERIFY;
    else if (pick < (pair_heavy ? 66 : 54)) c.cmd = CMD_PAIR;
    else if (pick < 72) c.cmd = CMD_SAVE;
    else if (pick < 78) c.cmd = CMD_SET_VER;
    else if (pick < 84) c.cmd = CMD_ERASE;
    else if (pick < (pair_heavy ? 85 : 87)) c.cmd = CMD_ERASE_ALL;
    else if (pick < 91) c.cmd = CMD_FIND_FREE;
    else if (pick < 97) c.cmd = CMD_CLEAR;
    else c.cmd = 4'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    if (c.cmd == CMD_VERIFY) begin
      base = peer_rec[c.slot].code;
      case ($urandom_range(0, 7))
        0: c.code_value = base;
        1: c.code_value = base + limit_now - 1;
        2: c.code_value = base + limit_now;
        3: c.code_value = base + limit_now / 2;
        4: c.code_value = base + limit_now / 2 - 1;
        5: c.code_value = base + $urandom_range(0, 300);
        6: c.code_value = base - $urandom_range(1, 4);
        default: ;
      endcase
    end
    if (c.cmd == CMD_SET_VER && $urandom_range(0, 1) != 0) begin
      k = match_row(1'b1, 1'b0, c.peer_type, c.peer_id);
      if (k >= 0) begin
        c.version_value = peer_rec[k].version;
      end
    end
    return c;
  endfunction

  task automatic issue_command(item_t c, bit typed, result_t want);
    result_t r;
    in_valid <= 1'b1;
    cmd <= c.cmd;
    peer_type <= c.peer_type;
    peer_id <= c.peer_id;
    code_value <= c.code_value;
    slot <= c.slot;
    model_value <= c.model_value;
    version_value <= c.version_value;
    clear_mask <= c.clear_mask;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = apply_command(c);
    due_results.push_back(typed ? want : r);
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 15);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_results();
    if (in_valid) begin
      in_valid <= 1'b0;
    end
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    limit_now = v;
  endtask

  always @(posedge clk) begin
    if (stall_count == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_count = $urandom_range(20, 80);
    end else begin
      stall_count--;
    end
    case (stall_style)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ($urandom_range(0, 4) != 0);
    endcase
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("result word arrived with none expected");
          fails++;
        end else begin
          want = due_results.pop_front();
          if (ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, ok);
            fails++;
          end
          if (hit_slot !== want.hit_slot) begin
            $error("hit_slot: expected %0d, got %0d", want.hit_slot, hit_slot);
            fails++;
          end
          if (advance !== want.advance) begin
            $error("advance: expected %0d, got %0d", want.advance, advance);
            fails++;
          end
          if (code_store_due !== want.code_store_due) begin
            $error("code_store_due: expected %0d, got %0d", want.code_store_due,
                   code_store_due);
            fails++;
          end
          if (table_store_due !== want.table_store_due) begin
            $error("table_store_due: expected %0d, got %0d", want.table_store_due,
                   table_store_due);
            fails++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] limits [SETTINGS_RUN];
    for (int i = 0; i < ENTRIES; i++) begin
      wipe_row(i);
    end
    code_dirty = 1'b0;
    table_dirty = 1'b0;
    limit_now = LIMIT_RESET;
    limits[0] = LIMIT_RESET;
    limits[1] = 32'd2;
    limits[2] = 32'hFFFF_FFFF;
    limits[3] = 32'd0;
    limits[4] = 32'd1;
    limits[5] = 32'd300;
    limits[6] = $urandom;
    limits[7] = LIMIT_RESET;

    plan.push_back(step(CMD_FIND_TI, 8'h00, 32'h0, 32'h0, 3'd0, 16'h0, 32'h0, 2'd0,
                        1'b1, {1'b0, 3'd0, 8'd0, 1'b0, 1'b0}));
    plan.push_back(step(CMD_FIND_FREE, 8'h00, 32'h0, 32'h0, 3'd0, 16'h0, 32'h0, 2'd0,
                        1'b1, {1'b1, 3'd0, 8'd0, 1'b0, 1'b0}));
    plan.push_back(step(CMD_VERIFY, 8'h00, 32'h0, 32'h0, 3'd0, 16'h0, 32'h0, 2'd0,
                        1'b1, {1'b1, 3'd0, 8'd0, 1'b0, 1'b0}));
    plan.push_back(step(CMD_PAIR, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0, 16'h0, 32'h0,
                        2'd0, 1'b1, {1'b1, 3'd0, 8'd0, 1'b1, 1'b1}));
    plan.push_back(step(CMD_CLEAR, 8'h00, 32'h0, 32'h0, 3'd0, 16'h0, 32'h0, 2'd3,
                        1'b1, {1'b1, 3'd0, 8'd0, 1'b0, 1'b0}));
    plan.push_back(step(CMD_PAIR, 8'h00, 32'h0, 32'h0, 3'd0, 16'h0, 32'h0, 2'd0));
    plan.push_back(step(CMD_FIND_ID, 8'h00, 32'hFFFF_FFFF, 32'h0, 3'd0, 16'h0, 32'h0, 2'd0));
    plan.push_back(step(CMD_FIND_TYPE, 8'h00, 32'h1, 32'h0, 3'd0, 16'h0, 32'h0, 2'd0));
    // The stored code wraps: a distance of exactly the limit is rejected, one less accepted.
    plan.push_back(step(CMD_VERIFY, 8'h00, 32'h0, 32'h3FF, 3'd0, 16'h0, 32'h0, 2'd0));
    plan.push_back(step(CMD_VERIFY, 8'h00, 32'h0, 32'h3FE, 3'd0, 16'h0, 32'h0, 2'd0));
    plan.push_back(step(CMD_CLEAR, 8'h00, 32'h0, 32'h0, 3'd0, 16'h0, 32'h0, 2'd1));
    plan.push_back(step(CMD_VERIFY, 8'h00, 32'h0, 32'd511, 3'd1, 16'h0, 32'h0, 2'd0));
    plan.push_back(step(CMD_VERIFY, 8'h00, 32'h0, 32'd511, 3'd1, 16'h0, 32'h0, 2'd0));
    plan.push_back(step(CMD_VERIFY, 8'h00, 32'h0, 32'd510, 3'd1, 16'h0, 32'h0, 2'd0));
    plan.push_back(step(CMD_SAVE, 8'h00, 32'h0, 32'd5, 3'd0, 16'hFFFF, 32'hFFFF_FFFF, 2'd0));
    plan.push_back(step(CMD_SAVE, 8'h01, 32'h0, 32'd9, 3'd0, 16'h1234, 32'h1, 2'd0));
    plan.push_back(step(CMD_CLEAR, 8'h00, 32'h0, 32'h0, 3'd0, 16'h0, 32'h0, 2'd2));
    plan.push_back(step(CMD_SET_VER, 8'h00, 32'h0, 32'h0, 3'd0, 16'h0, 32'hFFFF_FFFF, 2'd0));
    plan.push_back(step(CMD_SET_VER, 8'h00, 32'h0, 32'h0, 3'd0, 16'h0, 32'h0, 2'd0));
    plan.push_back(step(CMD_SET_VER, 8'h07, 32'h0, 32'h0, 3'd0, 16'h0, 32'h5, 2'd0));
    plan.push_back(step(CMD_ERASE, 8'h00, 32'h0, 32'h0, 3'd7, 16'h0, 32'h0, 2'd0));
    plan.push_back(step(CMD_ERASE, 8'h00, 32'h0, 32'h0, 3'd0, 16'h0, 32'h0, 2'd0));
    plan.push_back(step(CMD_VERIFY, 8'h00, 32'h0, 32'd5, 3'd0, 16'h0, 32'h0, 2'd0));
    plan.push_back(step(CMD_SPARE_LO, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 16'hFFFF,
                        32'hFFFF_FFFF, 2'd3));
    plan.push_back(step(CMD_SPARE_HI, 8'h00, 32'h0, 32'h0, 3'd0, 16'h0, 32'h0, 2'd0));
    plan.push_back(step(CMD_ERASE_ALL, 8'h00, 32'h0, 32'h0, 3'd0, 16'h0, 32'h0, 2'd0));
    plan.push_back(step(CMD_FIND_FREE, 8'h00, 32'h0, 32'h0, 3'd0, 16'h0, 32'h0, 2'd0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      issue_command(plan[i].word, plan[i].typed, plan[i].want);
    end

    for (int p = 0; p < SETTINGS_RUN; p++) begin
      pair_heavy = p[0];
      if (p != 0) begin
        drain_results();
        write_limit(limits[p]);
      end
      repeat (ITEMS_PER_SETTING) begin
        issue_command(random_command(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fails == 0 && due_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/ptrc_pkg.sv
rtl/ptrc_ram.sv
rtl/ptrc_ctrl.sv
rtl/pairing_table_rolling_code_check_unit.sv
tb/pairing_table_rolling_code_check_unit_tb.sv
